// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg: shared types for the bounded deque
// Opcodes, status codes and the control word that drives the row of cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FLD_W  = 5;   // width of the count and removed fields

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REM_FIRST  = 3'd4,
    OP_REM_ALL    = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // broadcast to every cell; a write at the addressed cell wins over a shift
  typedef struct packed {
    logic shift_up;
    logic shift_dn;
    logic wr_en;
  } cell_ctrl_t;

endpackage

// ===== rtl/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell: one storage cell of the deque
// Holds one entry; loads the broadcast word when addressed, otherwise takes
// its left or right neighbour on a shift, otherwise holds.
// ----------------------------------------------------------------------------
module bdq_cell #(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  bdq_pkg::cell_ctrl_t           ctrl_i,
  input  logic [IW-1:0]                 wr_pos_i,
  input  logic [bdq_pkg::DATA_W-1:0]    wr_data_i,
  input  logic [bdq_pkg::DATA_W-1:0]    left_i,
  input  logic [bdq_pkg::DATA_W-1:0]    right_i,
  output logic [bdq_pkg::DATA_W-1:0]    data_o
);

  logic [bdq_pkg::DATA_W-1:0] data_d, data_q;
  logic                       hit;

  assign hit = ctrl_i.wr_en && (wr_pos_i == IW'(IDX));

  always_comb begin
    if (hit) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift_up) begin
      data_d = left_i;
    end else if (ctrl_i.shift_dn) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/bounded_deque_with_value_removal.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_value_removal: bounded deque with removal by value
// Entries sit in a row of cells, front in cell 0. End operations shift or
// write the row or only move the count; removals rotate the row through a compare.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                         | tuser
//  s_axis   | in  | [31:0] value                  | [2:0] opcode
//  m_axis   | out | [4:0] count, [9:5] removed    | [1:0] status
//
//  Push and pop: the transfer loads the result register directly.
//  Remove first / remove all: after the accepting transfer the row is
//  rotated once through all held entries; each step pops cell 0, compares
//  it with the key and writes it back at the tail unless it is dropped.
//  Reset clears the count, the state and the result valid; cell contents
//  are left as they are. A new item is taken once no rotation is running
//  and the result register is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_removal #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [31:0] value
  input  logic [2:0]  s_axis_tuser,    // [2:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // [4:0] count, [9:5] removed, zero above
  output logic [1:0]  m_axis_tuser     // [1:0] status
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = bdq_pkg::DATA_W;
  localparam int unsigned FW = bdq_pkg::FLD_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e              state_d, state_q;
  logic [CW-1:0]       count_d, count_q;
  logic                m_valid_d, m_valid_q;
  logic [CW-1:0]       rem_d, rem_q;
  logic [IW-1:0]       wpos_d, wpos_q;
  logic [CW-1:0]       removed_d, removed_q;
  logic                found_d, found_q;
  logic                all_d, all_q;
  logic [DW-1:0]       key_d, key_q;
  bdq_pkg::status_e    out_status_d, out_status_q;
  logic [FW-1:0]       out_count_d, out_count_q;
  logic [FW-1:0]       out_removed_d, out_removed_q;

  bdq_pkg::cell_ctrl_t ctrl;
  logic [IW-1:0]       wr_pos;
  logic [DW-1:0]       wr_data;
  logic [DW-1:0]       cell_data [CAPACITY];
  logic                in_xfer;
  logic                drop;
  logic                res_valid;
  bdq_pkg::status_e    res_status;
  logic [CW-1:0]       res_removed;
  bdq_pkg::op_e        op;

  assign op            = bdq_pkg::op_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign drop          = (cell_data[0] == key_q) && (all_q || !found_q);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    rem_d         = rem_q;
    wpos_d        = wpos_q;
    removed_d     = removed_q;
    found_d       = found_q;
    all_d         = all_q;
    key_d         = key_q;
    out_status_d  = out_status_q;
    out_count_d   = out_count_q;
    out_removed_d = out_removed_q;
    ctrl          = '0;
    wr_pos        = '0;
    wr_data       = s_axis_tdata;
    res_valid     = 1'b0;
    res_status    = bdq_pkg::ST_OK;
    res_removed   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_valid = 1'b1;
          case (op)
            bdq_pkg::OP_PUSH_FRONT: begin
              if (count_q == CW'(CAPACITY)) begin
                res_status = bdq_pkg::ST_FULL;
              end else begin
                ctrl.shift_up = 1'b1;
                count_d       = count_q + CW'(1);
              end
            end
            bdq_pkg::OP_PUSH_BACK: begin
              if (count_q == CW'(CAPACITY)) begin
                res_status = bdq_pkg::ST_FULL;
              end else begin
                ctrl.wr_en = 1'b1;
                wr_pos     = IW'(count_q);
                count_d    = count_q + CW'(1);
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              if (count_q == '0) begin
                res_status = bdq_pkg::ST_EMPTY;
              end else begin
                ctrl.shift_dn = 1'b1;
                count_d       = count_q - CW'(1);
                res_removed   = CW'(1);
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              if (count_q == '0) begin
                res_status = bdq_pkg::ST_EMPTY;
              end else begin
                count_d     = count_q - CW'(1);
                res_removed = CW'(1);
              end
            end
            bdq_pkg::OP_REM_FIRST, bdq_pkg::OP_REM_ALL: begin
              if (count_q == '0) begin
                res_status = (op == bdq_pkg::OP_REM_FIRST) ? bdq_pkg::ST_EMPTY
                                                           : bdq_pkg::ST_OK;
              end else begin
                // start the rotation; result comes at its end
                res_valid = 1'b0;
                state_d   = S_SCAN;
                rem_d     = count_q;
                wpos_d    = IW'(count_q - CW'(1));
                removed_d = '0;
                found_d   = 1'b0;
                all_d     = (op == bdq_pkg::OP_REM_ALL);
                key_d     = s_axis_tdata;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // pop cell 0 and append it at the tail unless it is dropped (a match; for remove first only the first)
        ctrl.shift_dn = 1'b1;
        ctrl.wr_en    = !drop;
        wr_pos        = wpos_q;
        wr_data       = cell_data[0];
        wpos_d        = drop ? wpos_q - IW'(1) : wpos_q;
        removed_d     = removed_q + CW'(drop);
        found_d       = found_q || drop;
        rem_d         = rem_q - CW'(1);
        if (rem_q == CW'(1)) begin
          state_d     = S_IDLE;
          count_d     = count_q - removed_d;
          res_valid   = 1'b1;
          res_removed = removed_d;
          res_status  = (!all_q && !found_d) ? bdq_pkg::ST_NOT_FOUND : bdq_pkg::ST_OK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (res_valid) begin
      m_valid_d     = 1'b1;
      out_status_d  = res_status;
      out_count_d   = FW'(count_d);
      out_removed_d = FW'(res_removed);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = wr_data;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    bdq_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .wr_pos_i  (wr_pos),
      .wr_data_i (wr_data),
      .left_i    (left),
      .right_i   (right),
      .data_o    (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    wpos_q        <= wpos_d;
    removed_q     <= removed_d;
    found_q       <= found_d;
    all_q         <= all_d;
    key_q         <= key_d;
    out_status_q  <= out_status_d;
    out_count_q   <= out_count_d;
    out_removed_q <= out_removed_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(16 - 2 * FW){1'b0}}, out_removed_q, out_count_q};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && (rem_q == CW'(1)) |=> m_valid_q && (state_q == S_IDLE))
    else $error("rotation finished without a result");

  a_tail_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CW'(wpos_q) < count_q) && (rem_q != '0))
    else $error("tail position outside held entries");

  a_first_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && !all_q |-> (removed_q <= CW'(1)))
    else $error("remove first dropped more than one entry");

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !m_valid_q && !s_axis_tready)
    else $error("transfer overlaps a rotation");
`endif

endmodule
